FILE: design/utx_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the UART transmitter with byte FIFO.
// No dependencies; imported by every module of the block.
package utx_pkg;

   localparam int BYTE_W    = 8;
   localparam int USED_W    = 4;
   localparam int BITCNT_W  = 4;
   localparam int RSP_W     = 8;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_DATA  = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

   // Transmitter status seen by the FIFO control and the result path.
   typedef struct packed {
      logic busy;
      logic line;
   } frame_stat_type;

   // One result beat, packed highest field first: pad is bit 7, line_level bit 0.
   typedef struct packed {
      logic              pad;
      logic [USED_W-1:0] fifo_used;
      logic              busy_res;
      logic              accepted;
      logic              line_level;
   } rsp_type;

endpackage

FILE: design/utx_ram.sv
`timescale 1ns / 1ps
// Byte store of the transmit FIFO: one write port, one registered read port.
// Depends on utx_pkg for the byte width.
module utx_ram
   import utx_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold the read word until the next load; it serves as the shift byte.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/utx_frame.sv
`timescale 1ns / 1ps
// 8N1 frame sequencer: start bit, eight data bits LSB first, stop bit.
// Depends on utx_pkg for phase and status types.
module utx_frame
   import utx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start_go,
   input  logic              tick_go,
   input  logic [BYTE_W-1:0] shift_byte,
   output frame_stat_type    stat_cur,
   output frame_stat_type    stat_nxt
);

   phase_type             phase_ff, phase_in;
   logic [BITCNT_W-1:0]   cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  pin_ff, pin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         busy_ff  <= 1'b0;
         pin_ff   <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         busy_ff  <= busy_in;
         pin_ff   <= pin_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      pin_in   = pin_ff;
      if (start_go) begin
         busy_in  = 1'b1;
         phase_in = PH_START;
      end else if (tick_go && busy_ff) begin
         case (phase_ff)
            PH_IDLE: begin
               busy_in = 1'b0;
            end
            PH_START: begin
               pin_in   = 1'b0;
               cnt_in   = '0;
               phase_in = PH_DATA;
            end
            PH_DATA: begin
               pin_in = shift_byte[cnt_ff[2:0]];
               cnt_in = cnt_ff + 1'b1;
               if (cnt_in >= BITCNT_W'(BYTE_W)) begin
                  phase_in = PH_STOP;
               end
            end
            PH_STOP: begin
               pin_in   = 1'b1;
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   assign stat_cur = '{busy: busy_ff, line: pin_ff};
   assign stat_nxt = '{busy: busy_in, line: pin_in};

`ifndef ASSERT_OFF
   // An idle transmitter always leaves the line high.
   a_idle_high: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> pin_ff)
      else $error("line low while transmitter idle");

   // Start always enters the start-bit phase with busy set.
   a_start_phase: assert property (@(posedge clock) disable iff (reset)
      start_go |=> (busy_ff && phase_ff == PH_START))
      else $error("start did not enter start-bit phase");

   // The bit counter stays within one byte while shifting data.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (cnt_ff < BITCNT_W'(BYTE_W)))
      else $error("bit counter out of range in data phase");
`endif

endmodule

FILE: design/utx_skid.sv
`timescale 1ns / 1ps
// Two-entry result buffer between the transmitter core and the result stream.
// Depends on utx_pkg for the result beat type.
module utx_skid
   import utx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    has_room,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   rsp_type     ent_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        head_ff, head_in;
   logic        pop;
   logic        tail;

   assign pop       = out_valid && out_ready;
   assign tail      = head_ff ^ count_ff[0];
   assign has_room  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = ent_ff[head_ff];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      head_in  = head_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         head_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[tail] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   // Never write into a full buffer.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> has_room)
      else $error("result buffer overflow");

   // A beat held at the head does not change until it is taken.
   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
      else $error("pending result changed");

   // Count rises by one on a push without a pop; it moves by at most one per cycle.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("result count did not advance");
`endif

endmodule

FILE: design/uart_tx_fifo_serializer.sv
`timescale 1ns / 1ps
// Top level of the 8N1 UART transmitter fed from a byte ring FIFO.
// Depends on utx_pkg, utx_ram, utx_frame and utx_skid.
//
// Each request beat carries one operation in req_tuser: push a byte, start a
// frame, or advance the TX line by one bit time. Every beat produces exactly
// one response beat with the line level, an accepted flag, the busy flag and
// the FIFO fill, all taken after the operation. The block takes one beat per
// clock cycle, sustained, as long as responses drain; the FIFO pointers, the
// frame sequencer and the two-port byte memory all update in that same cycle.
// A two-entry response buffer lets a new request enter while one finished
// response still waits, so req_tready drops only when two responses are
// pending. The FIFO holds FIFO_DEPTH-1 bytes at most; a push into a full
// FIFO, or a start while busy or with nothing queued, is dropped with
// accepted low. A start reads the oldest byte into the memory's output
// register, which then serves as the shift byte; the first data bit goes out
// only after the start-bit tick, so no bypass is needed. The line rests high
// after reset and the byte memory needs no clearing.
module uart_tx_fifo_serializer
   import utx_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [1:0] req_tuser,   // [1:0] operation
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] line_level, [1] accepted, [2] busy_res,
                                   // [6:3] fifo_used, [7] zero
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = (PTR_W + 1 > USED_W) ? PTR_W + 1 : USED_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_next, rd_next;
   logic [CNT_W-1:0]  used;
   logic              accept;
   op_type            op;
   logic              push_ok, start_ok, tick_go;
   logic [BYTE_W-1:0] shift_byte;
   frame_stat_type    stat_cur, stat_nxt;
   rsp_type           rsp_in, rsp_out;
   logic              room;

   assign accept = req_tvalid && req_tready;
   assign op     = op_type'(req_tuser);

   // Wrap pointers at the configured depth, not at a power of two.
   assign wr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;

   // One slot stays empty to tell full from empty.
   assign push_ok  = accept && (op == OP_PUSH) && (wr_next != rd_ptr_ff);
   assign start_ok = accept && (op == OP_START) && !stat_cur.busy
                     && (wr_ptr_ff != rd_ptr_ff);
   assign tick_go  = accept && (op == OP_TICK);

   assign wr_ptr_in = push_ok  ? wr_next : wr_ptr_ff;
   assign rd_ptr_in = start_ok ? rd_next : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Fill after this beat, modulo the depth; report the low four bits.
   always_comb begin
      if (wr_ptr_in >= rd_ptr_in) begin
         used = CNT_W'(wr_ptr_in) - CNT_W'(rd_ptr_in);
      end else begin
         used = CNT_W'(wr_ptr_in) + CNT_W'(FIFO_DEPTH) - CNT_W'(rd_ptr_in);
      end
   end

   utx_ram #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_tdata),
      .rd_en   (start_ok),
      .rd_addr (rd_ptr_ff),
      .rd_data (shift_byte)
   );

   utx_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .start_go   (start_ok),
      .tick_go    (tick_go),
      .shift_byte (shift_byte),
      .stat_cur   (stat_cur),
      .stat_nxt   (stat_nxt)
   );

   assign rsp_in = '{pad:        1'b0,
                     fifo_used:  used[USED_W-1:0],
                     busy_res:   stat_nxt.busy,
                     accepted:   push_ok || start_ok,
                     line_level: stat_nxt.line};

   utx_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rsp_in),
      .has_room  (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_out)
   );

   assign req_tready = room;
   assign rsp_tdata  = rsp_out;

`ifndef ASSERT_OFF
   // A stored byte always advances the write pointer.
   a_push_adv: assert property (@(posedge clock) disable iff (reset)
      push_ok |=> (wr_ptr_ff != $past(wr_ptr_ff)))
      else $error("push did not advance write pointer");

   // The read pointer moves only when a frame starts.
   a_rd_move: assert property (@(posedge clock) disable iff (reset)
      !start_ok |=> $stable(rd_ptr_ff))
      else $error("read pointer moved without a start");

   // A tick while idle leaves the transmitter untouched.
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (tick_go && !stat_cur.busy) |=> $stable(stat_cur))
      else $error("idle tick changed transmitter state");
`endif

endmodule

FILE: tb/uart_tx_fifo_serializer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for uart_tx_fifo_serializer (8N1 transmitter with byte FIFO).
// Depends on utx_pkg and the RTL of the block; needs no files or arguments.
module uart_tx_fifo_serializer_tb;
   import utx_pkg::*;

   localparam int RING_DEPTH  = 16;
   localparam int ITEM_TARGET = 1200;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 20;
   localparam int HOLD_OFF    = 250;

   // Track the transmitter line, busy flag and FIFO fill for every accepted
   // request beat, and hold the response beats still due.
   class uart_tx_tracker;
      logic [BYTE_W-1:0]   ring [RING_DEPTH];
      int unsigned         wr_ptr;
      int unsigned         rd_ptr;
      logic                busy;
      logic                line;
      phase_type           phase;
      logic [BYTE_W-1:0]   shifter;
      logic [BITCNT_W-1:0] bit_cnt;
      rsp_type             due_q[$];
      int unsigned         beats_seen;
      int unsigned         mismatches;

      function new();
         wr_ptr     = 0;
         rd_ptr     = 0;
         busy       = 1'b0;
         line       = 1'b1;
         phase      = PH_IDLE;
         shifter    = '0;
         bit_cnt    = '0;
         beats_seen = 0;
         mismatches = 0;
      endfunction

      // Apply one request beat and queue the response it must produce.
      function void take_request(op_type op, logic [BYTE_W-1:0] data);
         rsp_type     due;
         logic        acc;
         int unsigned fill;
         acc = 1'b0;
         case (op)
            OP_PUSH: begin
               if ((wr_ptr + 1) % RING_DEPTH != rd_ptr) begin
                  ring[wr_ptr] = data;
                  wr_ptr       = (wr_ptr + 1) % RING_DEPTH;
                  acc          = 1'b1;
               end
            end
            OP_START: begin
               if (!busy && wr_ptr != rd_ptr) begin
                  shifter = ring[rd_ptr];
                  rd_ptr  = (rd_ptr + 1) % RING_DEPTH;
                  busy    = 1'b1;
                  phase   = PH_START;
                  acc     = 1'b1;
               end
            end
            OP_TICK: begin
               if (busy) begin
                  case (phase)
                     PH_IDLE: busy = 1'b0;
                     PH_START: begin
                        line    = 1'b0;
                        bit_cnt = '0;
                        phase   = PH_DATA;
                     end
                     PH_DATA: begin
                        line    = shifter[bit_cnt[2:0]];
                        bit_cnt = bit_cnt + 1'b1;
                        if (bit_cnt >= 8) phase = PH_STOP;
                     end
                     default: begin
                        line  = 1'b1;
                        phase = PH_IDLE;
                     end
                  endcase
               end
            end
            default: ;
         endcase
         fill           = (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
         due.pad        = 1'b0;
         due.fifo_used  = fill[USED_W-1:0];
         due.busy_res   = busy;
         due.accepted   = acc;
         due.line_level = line;
         due_q.push_back(due);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("mismatch at response %0d: %s got %0h want %0h",
                  beats_seen, what, got, want);
         mismatches++;
      endtask

      // Compare one response beat with the oldest one due.
      task check_response(logic [RSP_W-1:0] beat);
         rsp_type got;
         rsp_type want;
         got = rsp_type'(beat);
         beats_seen++;
         if (due_q.size() == 0) begin
            report_mismatch("unexpected response", beat, 0);
         end else begin
            want = due_q.pop_front();
            if (got.line_level !== want.line_level)
               report_mismatch("line_level", got.line_level, want.line_level);
            if (got.accepted !== want.accepted)
               report_mismatch("accepted", got.accepted, want.accepted);
            if (got.busy_res !== want.busy_res)
               report_mismatch("busy_res", got.busy_res, want.busy_res);
            if (got.fifo_used !== want.fifo_used)
               report_mismatch("fifo_used", got.fifo_used, want.fifo_used);
            if (got.pad !== want.pad)
               report_mismatch("pad bit", got.pad, want.pad);
         end
      endtask
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata  = '0;   // [7:0] data_byte
   logic [1:0]        req_tuser  = OP_NONE;   // [1:0] operation
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;   // [0] line_level, [1] accepted, [2] busy_res,
                                   // [6:3] fifo_used, [7] zero

   uart_tx_tracker tracker = new();
   int unsigned    items_sent  = 0;
   int unsigned    cycle_count = 0;
   bit             sender_eager = 1'b0;

   uart_tx_fifo_serializer #(.FIFO_DEPTH(RING_DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Bound the run; a hang anywhere ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Offer one request beat and return at the edge that accepts it. Valid is
   // only lowered when a gap follows, so back-to-back beats keep it high and
   // each signal sees a single nonblocking write per time step.
   task automatic send_beat(op_type op, logic [BYTE_W-1:0] data);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      tracker.take_request(op, data);
      if (op != OP_NONE) items_sent++;
   endtask

   task automatic send_random_byte(op_type op);
      send_beat(op, BYTE_W'($urandom_range(0, 255)));
   endtask

   // One full frame worth of bit ticks: start bit, eight data bits, stop bit
   // and the tick that clears busy.
   task automatic send_frame_ticks(bit sprinkle);
      for (int t = 0; t < 11; t++) begin
         // Mix in pushes and stray starts mid-frame now and then.
         if (sprinkle && $urandom_range(0, 9) < 2)
            send_random_byte($urandom_range(0, 3) == 0 ? OP_START : OP_PUSH);
         send_random_byte(OP_TICK);
      end
   endtask

   // Response side: take beats with random stalls, stretches of steady
   // readiness, and two long hold-offs that back the block up into its input.
   initial begin
      int  stall;
      bit  rsp_eager;
      rsp_eager = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) rsp_eager = ~rsp_eager;
         stall = rsp_eager ? 0 : $urandom_range(0, 10);
         if (tracker.beats_seen == 300 || tracker.beats_seen == 800) stall = HOLD_OFF;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_response(rsp_tdata);
      end
   end

   // Request side: directed beats first, then random sequences.
   initial begin
      int kind;
      int count;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Tick and start with nothing to do, then an unused operation code.
      send_beat(OP_TICK,  8'h00);
      send_beat(OP_START, 8'hFF);
      send_beat(OP_NONE,  8'hA5);
      // Queue the extreme bytes and send the first one.
      send_beat(OP_PUSH,  8'hFF);
      send_beat(OP_PUSH,  8'h00);
      send_beat(OP_START, 8'h00);
      // Start while busy is dropped; a push while busy still lands.
      send_beat(OP_START, 8'h00);
      send_beat(OP_PUSH,  8'h5A);
      send_frame_ticks(1'b0);
      // Tick once more with the transmitter idle.
      send_beat(OP_TICK,  8'hFF);

      while (items_sent < ITEM_TARGET) begin
         sender_eager = ($urandom_range(0, 4) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            // Well-formed frame: queue zero to three bytes, start, clock out.
            count = $urandom_range(0, 3);
            repeat (count) send_random_byte(OP_PUSH);
            send_random_byte(OP_START);
            send_frame_ticks(1'b1);
         end else if (kind < 60) begin
            // Burst of pushes to run the FIFO into full.
            count = $urandom_range(14, 18);
            repeat (count) send_random_byte(OP_PUSH);
         end else if (kind < 78) begin
            // Drain queued bytes frame by frame.
            count = $urandom_range(1, 4);
            repeat (count) begin
               send_random_byte(OP_START);
               send_frame_ticks(1'b0);
            end
         end else begin
            // Noise: any operation, including the unused code.
            count = $urandom_range(1, 6);
            repeat (count) send_random_byte(op_type'($urandom_range(0, 3)));
         end
      end
      req_tvalid <= 1'b0;

      while (tracker.due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
